/* sv/tower_hit_threshold_filter_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tower hit threshold filter
// Shared shorthands for the concurrent checks in the filter modules.
// ----------------------------------------------------------------------------
`ifndef TOWER_HIT_THRESHOLD_FILTER_TOP_MACROS_SVH
`define TOWER_HIT_THRESHOLD_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define THF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define THF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/thf_pkg.sv */
// ----------------------------------------------------------------------------
// thf_pkg
// Constants, codes and the queue item type of the tower hit threshold filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thf_pkg;

  // Sizes.
  localparam int MAP_DEPTH = 8192;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int MAX_LIST  = 64;
  localparam int LIST_W    = $clog2(MAX_LIST + 1);
  localparam int RAW_SLOTS = 32;
  localparam int LIST_FLOOR = 10;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int QLVL_W  = $clog2(Q_DEPTH + 1);

  // Field widths.
  localparam int CHAN_W  = 13;
  localparam int ADC_W   = 12;
  localparam int TOWER_W = 13;
  localparam int SLOT_W  = 6;
  localparam int SUM_W   = 24;
  localparam int COUNT_W = 8;
  localparam int WORD_W  = 32;

  localparam logic [SUM_W-1:0]   SUM_MAX   = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Result kinds.
  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_RAW = 2'd1;
  localparam logic [1:0] KIND_HDR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MAX_LIST  = 2'd1;
  localparam logic [1:0] CFG_IS_BARREL = 2'd2;
  localparam int CFG_W = 12;

  // Configuration reset values.
  localparam logic [ADC_W-1:0] THRESHOLD_RESET = 12'd10;
  localparam logic [6:0]       MAX_LIST_RESET  = 7'd10;
  localparam logic             IS_BARREL_RESET = 1'b1;

  // One classified hit with the results it causes.
  typedef struct packed {
    logic                raw_en;
    logic                acc_en;
    logic                hdr_en;
    logic                in_range;
    logic [SLOT_W-1:0]   raw_slot;
    logic [SLOT_W-1:0]   acc_slot;
    logic [ADC_W-1:0]    adc;
    logic [TOWER_W-1:0]  tower;
    logic [WORD_W-1:0]   hdr_word;
  } item_t;

endpackage

`default_nettype wire

/* sv/thf_ram.sv */
// ----------------------------------------------------------------------------
// thf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/thf_front.sv */
// ----------------------------------------------------------------------------
// thf_front
// Accepts items, loads the tower map, keeps the event state and classifies
// each hit into the results it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thf_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [thf_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             mode,
  input  wire logic [thf_pkg::CHAN_W-1:0]       channel,
  input  wire logic [thf_pkg::ADC_W-1:0]        adc,
  input  wire logic [thf_pkg::TOWER_W-1:0]      tower_id,
  input  wire logic                             last_hit,
  input  wire logic [thf_pkg::QLVL_W-1:0]       q_level,
  output logic                                  push,
  output thf_pkg::item_t                        push_item
);

  // Configuration registers.
  logic [thf_pkg::ADC_W-1:0] adc_threshold;
  logic [6:0]                max_list;
  logic                      is_barrel;

  // Event state.
  logic [thf_pkg::SUM_W-1:0]   adc_sum, adc_sum_next;
  logic [thf_pkg::COUNT_W-1:0] hit_count, hit_count_next;
  logic [thf_pkg::LIST_W-1:0]  list_count, list_count_next;
  logic                        stopped, stopped_next;

  // Stage between accept and the map read data.
  logic           s1_valid;
  thf_pkg::item_t s1_item;
  thf_pkg::item_t cls_item;

  logic                          accept, hit, load, in_range;
  logic [thf_pkg::MAP_AW-1:0]    map_addr;
  logic [thf_pkg::TOWER_W-1:0]   map_rdata;
  logic [thf_pkg::LIST_W-1:0]    limit;
  logic [31:0]                   limit_wide;
  logic [thf_pkg::SUM_W:0]       sum_wide;
  logic [thf_pkg::SUM_W-1:0]     sum_hit;
  logic                          raw_en, acc_en;
  logic [thf_pkg::LIST_W-1:0]    list_hit;

  // Room in the queue is counted for the item in flight as well.
  assign in_stall = (32'(q_level) + 32'(s1_valid)) >= thf_pkg::Q_DEPTH;
  assign accept   = in_valid && !in_stall;
  assign hit      = accept && mode;
  assign load     = accept && !mode && in_range;
  assign in_range = 32'(channel) < thf_pkg::MAP_DEPTH;
  assign map_addr = thf_pkg::MAP_AW'(channel);

  // Tower map: loads write it, every cycle reads at the incoming channel.
  thf_ram #(
    .WIDTH(thf_pkg::TOWER_W),
    .DEPTH(thf_pkg::MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (load),
    .waddr(map_addr),
    .wdata(tower_id),
    .raddr(map_addr),
    .rdata(map_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_threshold <= thf_pkg::THRESHOLD_RESET;
      max_list      <= thf_pkg::MAX_LIST_RESET;
      is_barrel     <= thf_pkg::IS_BARREL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thf_pkg::CFG_THRESHOLD: adc_threshold <= cfg_data;
        thf_pkg::CFG_MAX_LIST:  max_list      <= cfg_data[6:0];
        thf_pkg::CFG_IS_BARREL: is_barrel     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // List size clamped to its legal range.
  always_comb begin
    limit_wide = 32'(max_list);
    if (limit_wide < thf_pkg::LIST_FLOOR) begin
      limit_wide = thf_pkg::LIST_FLOOR;
    end
    if (limit_wide > thf_pkg::MAX_LIST) begin
      limit_wide = thf_pkg::MAX_LIST;
    end
    limit = thf_pkg::LIST_W'(limit_wide);
  end

  // Classification of one hit and the next event state.
  always_comb begin
    sum_wide = {1'b0, adc_sum} + (thf_pkg::SUM_W + 1)'(adc);
    sum_hit  = sum_wide[thf_pkg::SUM_W] ? thf_pkg::SUM_MAX : sum_wide[thf_pkg::SUM_W-1:0];
    raw_en   = !stopped && is_barrel && (32'(hit_count) < thf_pkg::RAW_SLOTS);
    acc_en   = !stopped && (list_count < limit) && (adc >= adc_threshold);
    list_hit = list_count + thf_pkg::LIST_W'(acc_en);

    adc_sum_next    = stopped ? adc_sum : sum_hit;
    list_count_next = list_hit;
    stopped_next    = stopped ||
                      ((list_hit >= limit) && (32'(hit_count) >= thf_pkg::RAW_SLOTS));
    hit_count_next  = (hit_count < thf_pkg::COUNT_MAX) ? hit_count + 8'd1 : hit_count;

    cls_item          = '0;
    cls_item.raw_en   = raw_en;
    cls_item.acc_en   = acc_en;
    cls_item.hdr_en   = last_hit;
    cls_item.in_range = in_range;
    cls_item.raw_slot = thf_pkg::SLOT_W'(hit_count);
    cls_item.acc_slot = thf_pkg::SLOT_W'(list_count);
    cls_item.adc      = adc;
    cls_item.hdr_word = {hit_count_next, adc_sum_next};
  end

  // Event state registers; the last hit clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_sum    <= '0;
      hit_count  <= '0;
      list_count <= '0;
      stopped    <= 1'b0;
    end else if (hit) begin
      if (last_hit) begin
        adc_sum    <= '0;
        hit_count  <= '0;
        list_count <= '0;
        stopped    <= 1'b0;
      end else begin
        adc_sum    <= adc_sum_next;
        hit_count  <= hit_count_next;
        list_count <= list_count_next;
        stopped    <= stopped_next;
      end
    end
  end

  // Hold the classified hit while the map read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      s1_item <= cls_item;
    end
  end

  // Merge the tower and push only hits that cause a result.
  always_comb begin
    push_item       = s1_item;
    push_item.tower = s1_item.in_range ? map_rdata : '0;
    push = s1_valid && (s1_item.raw_en || s1_item.acc_en || s1_item.hdr_en);
  end

endmodule

`default_nettype wire

/* sv/thf_queue.sv */
// ----------------------------------------------------------------------------
// thf_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tower_hit_threshold_filter_top_macros.svh"

module thf_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire thf_pkg::item_t             push_item,
  input  wire logic                       pop,
  output thf_pkg::item_t                  head,
  output logic [thf_pkg::QLVL_W-1:0]      level
);

  thf_pkg::item_t            entries [thf_pkg::Q_DEPTH];
  logic [thf_pkg::Q_AW-1:0]  wr_ptr, rd_ptr;

  function automatic logic [thf_pkg::Q_AW-1:0] ptr_inc(input logic [thf_pkg::Q_AW-1:0] p);
    return (p == thf_pkg::Q_AW'(thf_pkg::Q_DEPTH - 1)) ? '0 : p + thf_pkg::Q_AW'(1);
  endfunction

  assign head = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        level <= level + thf_pkg::QLVL_W'(1);
      end else if (pop && !push) begin
        level <= level - thf_pkg::QLVL_W'(1);
      end
    end
  end

  // Checks on the queue bookkeeping.
  `THF_ASSERT_IMP(a_no_overflow, push && !pop, 32'(level) < thf_pkg::Q_DEPTH, "queue overflow")
  `THF_ASSERT_IMP(a_no_underflow, pop, level != '0, "pop from empty queue")
  `THF_ASSERT_NEXT(a_level_up, push && !pop, level == $past(level) + thf_pkg::QLVL_W'(1), "level did not rise")

endmodule

`default_nettype wire

/* sv/thf_back.sv */
// ----------------------------------------------------------------------------
// thf_back
// Walks the results of the head item in the order raw, accepted, header and
// delivers them one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tower_hit_threshold_filter_top_macros.svh"

module thf_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire thf_pkg::item_t               head,
  input  wire logic [thf_pkg::QLVL_W-1:0]   level,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        kind,
  output logic [thf_pkg::SLOT_W-1:0]        slot,
  output logic [thf_pkg::WORD_W-1:0]        word,
  output logic                              last
);

  logic raw_done, acc_done;
  logic show_raw, show_acc, final_result, fire;
  logic [thf_pkg::WORD_W-1:0] hit_word;

  assign out_valid = level != '0;
  assign fire      = out_valid && !out_stall;
  assign hit_word  = {4'b0, head.adc, 3'b0, head.tower};

  // Pick the next result of the head item.
  always_comb begin
    show_raw = head.raw_en && !raw_done;
    show_acc = head.acc_en && !acc_done && !show_raw;
    if (show_raw) begin
      kind         = thf_pkg::KIND_RAW;
      slot         = head.raw_slot;
      word         = hit_word;
      last         = 1'b0;
      final_result = !(head.acc_en || head.hdr_en);
    end else if (show_acc) begin
      kind         = thf_pkg::KIND_ACC;
      slot         = head.acc_slot;
      word         = hit_word;
      last         = 1'b0;
      final_result = !head.hdr_en;
    end else begin
      kind         = thf_pkg::KIND_HDR;
      slot         = '0;
      word         = head.hdr_word;
      last         = 1'b1;
      final_result = 1'b1;
    end
  end

  assign pop = fire && final_result;

  // Marks of the results already delivered for the head item.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_done <= 1'b0;
      acc_done <= 1'b0;
    end else if (fire) begin
      if (final_result) begin
        raw_done <= 1'b0;
        acc_done <= 1'b0;
      end else if (show_raw) begin
        raw_done <= 1'b1;
      end else begin
        acc_done <= 1'b1;
      end
    end
  end

  // Checks on the result sequencing.
  `THF_ASSERT_IMP(a_head_has_result, out_valid, head.raw_en || head.acc_en || head.hdr_en, "queued item without result")
  `THF_ASSERT_IMP(a_marks_need_head, raw_done || acc_done, out_valid, "done marks without a head item")
  `THF_ASSERT_IMP(a_acc_mark_order, acc_done, !head.raw_en || raw_done, "accepted word before raw word")

endmodule

`default_nettype wire

/* sv/tower_hit_threshold_filter_top.sv */
// ----------------------------------------------------------------------------
// tower_hit_threshold_filter_top
// Per-event hit filter: channel to tower mapping, raw and accepted words and
// an event header.
// ----------------------------------------------------------------------------
// The block takes one input item in every cycle while the result queue has
// room. A map load writes the 8192-entry tower map and gives no result. A
// hit is classified at once (sum, counts, raw and accepted decisions), its
// tower comes from the map RAM in the next cycle, and it then waits in a
// four-entry queue. Results leave one per cycle while the receiver does not
// stall, in the order raw, accepted, header; a hit causes zero to three
// results. The output port and its one-result-per-cycle sequencer set the
// sustained rate: one hit per cycle while hits cause at most one result each
// and the receiver does not stall. The map has no reset; a hit on a channel
// that was never loaded returns an arbitrary tower.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tower_hit_threshold_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [thf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [thf_pkg::CHAN_W-1:0]    channel,
  input  wire logic [thf_pkg::ADC_W-1:0]     adc,
  input  wire logic [thf_pkg::TOWER_W-1:0]   tower_id,
  input  wire logic                          last_hit,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         kind,
  output logic [thf_pkg::SLOT_W-1:0]         slot,
  output logic [thf_pkg::WORD_W-1:0]         word,
  output logic                               last
);

  logic                        push, pop;
  thf_pkg::item_t              push_item, head;
  logic [thf_pkg::QLVL_W-1:0]  level;

  // Front part: accept, map and classify.
  thf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .channel  (channel),
    .adc      (adc),
    .tower_id (tower_id),
    .last_hit (last_hit),
    .q_level  (level),
    .push     (push),
    .push_item(push_item)
  );

  // Queue between the two parts.
  thf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .level    (level)
  );

  // Back part: deliver the results.
  thf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .level    (level),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .slot     (slot),
    .word     (word),
    .last     (last)
  );

endmodule

`default_nettype wire

/* bench/tower_hit_threshold_filter_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tower hit threshold filter testbench
// Drives map loads and hit events through the filter and predicts every raw,
// accepted and header word in step with the accepted items. Each result is
// checked field by field against the oldest prediction. The run goes through
// several register settings and sender and receiver idling profiles. It
// includes a long receiver hold during an event that fills its list and
// stops early.
// ----------------------------------------------------------------------------

module tower_hit_threshold_filter_top_test;

  typedef struct packed {
    logic                        mode;
    logic [thf_pkg::CHAN_W-1:0]  channel;
    logic [thf_pkg::ADC_W-1:0]   adc;
    logic [thf_pkg::TOWER_W-1:0] tower_id;
    logic                        last_hit;
  } hit_item_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [thf_pkg::SLOT_W-1:0] slot;
    logic [thf_pkg::WORD_W-1:0] word;
    logic                       last;
  } filter_word_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_HIT  = 1'b1;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   HOLD_CYCLES  = 300;
  localparam longint TIMEOUT_NS = 64'd1_000_000;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_index = '0;
  logic [thf_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_mode = 1'b0;
  logic [thf_pkg::CHAN_W-1:0]   in_channel = '0;
  logic [thf_pkg::ADC_W-1:0]    in_adc = '0;
  logic [thf_pkg::TOWER_W-1:0]  in_tower_id = '0;
  logic                         in_last_hit = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_kind;
  logic [thf_pkg::SLOT_W-1:0]   out_slot;
  logic [thf_pkg::WORD_W-1:0]   out_word;
  logic                         out_last;

  tower_hit_threshold_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (in_mode),
    .channel   (in_channel),
    .adc       (in_adc),
    .tower_id  (in_tower_id),
    .last_hit  (in_last_hit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (out_kind),
    .slot      (out_slot),
    .word      (out_word),
    .last      (out_last)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stimulus and expected-result stores.
  hit_item_t    stim_q[$];
  filter_word_t expected_words[$];
  hit_item_t    cur_item;

  // Channels that hold a tower, so hits never read an unwritten entry.
  bit                         is_mapped[thf_pkg::MAP_DEPTH];
  logic [thf_pkg::CHAN_W-1:0] mapped_chans[$];
  int                         queued_hits = 0;

  // Idling profile and receiver hold request.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;

  // Filter state and register copies kept by the predictor.
  logic [thf_pkg::TOWER_W-1:0] tower_map_copy[thf_pkg::MAP_DEPTH];
  int unsigned                 ev_sum = 0;
  int unsigned                 ev_hits = 0;
  int unsigned                 ev_listed = 0;
  bit                          ev_stopped = 1'b0;
  logic [thf_pkg::ADC_W-1:0]   thr_q = thf_pkg::THRESHOLD_RESET;
  logic [6:0]                  list_max_q = thf_pkg::MAX_LIST_RESET;
  logic                        barrel_q = thf_pkg::IS_BARREL_RESET;

  // Run statistics.
  int n_errors = 0;
  int n_hits = 0;
  int n_loads = 0;
  int n_events = 0;
  int n_stopped = 0;
  int n_by_kind[4] = '{default: 0};

  function automatic void push_word(logic [1:0] k, int unsigned s,
                                    logic [thf_pkg::WORD_W-1:0] w, logic l);
    filter_word_t r;
    r.kind = k;
    r.slot = thf_pkg::SLOT_W'(s);
    r.word = w;
    r.last = l;
    expected_words.push_back(r);
  endfunction

  // Works out the words that one accepted item causes and advances the state.
  function automatic void predict_filter(hit_item_t it);
    int unsigned                idx;
    int unsigned                lim;
    logic [thf_pkg::WORD_W-1:0] packed_word;
    if (it.mode == MODE_LOAD) begin
      tower_map_copy[it.channel] = it.tower_id;
      n_loads++;
      return;
    end
    n_hits++;
    if (!ev_stopped) begin
      idx = ev_hits;
      packed_word = (thf_pkg::WORD_W'(it.adc) << 16) |
                    thf_pkg::WORD_W'(tower_map_copy[it.channel]);
      lim = list_max_q;
      if (lim < thf_pkg::LIST_FLOOR) lim = thf_pkg::LIST_FLOOR;
      if (lim > thf_pkg::MAX_LIST) lim = thf_pkg::MAX_LIST;
      ev_sum += it.adc;
      if (ev_sum > thf_pkg::SUM_MAX) ev_sum = thf_pkg::SUM_MAX;
      if (barrel_q && idx < thf_pkg::RAW_SLOTS) begin
        push_word(thf_pkg::KIND_RAW, idx, packed_word, 1'b0);
      end
      if (ev_listed < lim && it.adc >= thr_q) begin
        push_word(thf_pkg::KIND_ACC, ev_listed, packed_word, 1'b0);
        ev_listed++;
      end
      if (ev_listed >= lim && idx >= thf_pkg::RAW_SLOTS) begin
        ev_stopped = 1'b1;
        n_stopped++;
      end
    end
    if (ev_hits < thf_pkg::COUNT_MAX) ev_hits++;
    if (it.last_hit) begin
      push_word(thf_pkg::KIND_HDR, 0,
                (thf_pkg::WORD_W'(ev_hits) << 24) | thf_pkg::WORD_W'(ev_sum), 1'b1);
      n_events++;
      ev_sum = 0;
      ev_hits = 0;
      ev_listed = 0;
      ev_stopped = 1'b0;
    end
  endfunction

  function automatic void report_field(string name, logic [thf_pkg::WORD_W-1:0] want,
                                       logic [thf_pkg::WORD_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    n_errors++;
  endfunction

  // Driver: offers queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_filter(cur_item);
      end
      if (!in_valid || !in_stall) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = stim_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= cur_item.mode;
          in_channel <= cur_item.channel;
          in_adc <= cur_item.adc;
          in_tower_id <= cur_item.tower_id;
          in_last_hit <= cur_item.last_hit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted here in cycles and applied by the monitor.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor: checks each accepted result and drives the receiver stall.
  always @(posedge clk) begin
    filter_word_t got;
    filter_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = out_kind;
        got.slot = out_slot;
        got.word = out_word;
        got.last = out_last;
        n_by_kind[got.kind]++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result, kind %0d slot %0d word %h last %0d",
                   $time, got.kind, got.slot, got.word, got.last);
          n_errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind) report_field("kind", want.kind, got.kind);
          if (got.slot !== want.slot) report_field("slot", want.slot, got.slot);
          if (got.word !== want.word) report_field("word", want.word, got.word);
          if (got.last !== want.last) report_field("last", want.last, got.last);
        end
      end
      // A running long hold takes priority over the random stall.
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic write_cfg(input logic [1:0] idx, input logic [thf_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      thf_pkg::CFG_THRESHOLD: thr_q = data[thf_pkg::ADC_W-1:0];
      thf_pkg::CFG_MAX_LIST:  list_max_q = data[6:0];
      thf_pkg::CFG_IS_BARREL: barrel_q = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int thr, input int list_max, input int barrel);
    write_cfg(thf_pkg::CFG_THRESHOLD, thf_pkg::CFG_W'(thr));
    write_cfg(thf_pkg::CFG_MAX_LIST, thf_pkg::CFG_W'(list_max));
    write_cfg(thf_pkg::CFG_IS_BARREL, thf_pkg::CFG_W'(barrel));
    @(negedge clk);
  endtask

  task automatic queue_load(input logic [thf_pkg::CHAN_W-1:0] ch,
                            input logic [thf_pkg::TOWER_W-1:0] tw);
    hit_item_t it;
    it = '{mode: MODE_LOAD, channel: ch, adc: thf_pkg::ADC_W'($urandom), tower_id: tw,
           last_hit: 1'($urandom)};
    stim_q.push_back(it);
    if (!is_mapped[ch]) begin
      is_mapped[ch] = 1'b1;
      mapped_chans.push_back(ch);
    end
  endtask

  task automatic queue_hit(input logic [thf_pkg::CHAN_W-1:0] ch,
                           input logic [thf_pkg::ADC_W-1:0] a, input logic lst);
    hit_item_t it;
    it = '{mode: MODE_HIT, channel: ch, adc: a, tower_id: thf_pkg::TOWER_W'($urandom),
           last_hit: lst};
    stim_q.push_back(it);
    queued_hits++;
  endtask

  // One event of random hits on mapped channels, with occasional map loads.
  task automatic queue_event(input int n);
    int                        near;
    logic [thf_pkg::ADC_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) begin
        queue_load(thf_pkg::CHAN_W'($urandom), thf_pkg::TOWER_W'($urandom));
      end
      case ($urandom_range(7))
        0: a = '0;
        1: a = '1;
        2, 3: begin
          near = int'(thr_q) + int'($urandom_range(4)) - 2;
          if (near < 0) near = 0;
          if (near > 4095) near = 4095;
          a = thf_pkg::ADC_W'(near);
        end
        default: a = thf_pkg::ADC_W'($urandom);
      endcase
      queue_hit(mapped_chans[$urandom_range(mapped_chans.size() - 1)], a, i == n - 1);
    end
  endtask

  // Blocks until every item is in and every word is out, then lets it settle.
  task automatic wait_quiet();
    @(negedge clk);
    while (stim_q.size() != 0 || in_valid || expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One phase of random events under one setting and idling profile.
  task automatic run_phase(input int thr, input int list_max, input int barrel,
                           input int send_pct, input int recv_pct, input int nhits);
    int start;
    int sel;
    set_config(thr, list_max, barrel);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    start = queued_hits;
    while (queued_hits - start < nhits) begin
      sel = $urandom_range(9);
      if (sel < 6) queue_event($urandom_range(1, 8));
      else if (sel < 9) queue_event($urandom_range(9, 40));
      else queue_event($urandom_range(33, 72));
    end
    wait_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, threshold edges and a load inside an event.
    set_config(thf_pkg::THRESHOLD_RESET, thf_pkg::MAX_LIST_RESET, thf_pkg::IS_BARREL_RESET);
    queue_load(13'h0000, 13'h1FFF);
    queue_load(13'h1FFF, 13'h0000);
    queue_load(13'h1555, 13'h0AAA);
    queue_load(13'h0AAA, 13'h1555);
    queue_hit(13'h0000, 12'd0, 1'b0);
    queue_hit(13'h1FFF, 12'hFFF, 1'b0);
    queue_hit(13'h1555, 12'd9, 1'b0);
    queue_load(13'h0AAA, 13'h1234);
    queue_hit(13'h0AAA, 12'd10, 1'b1);
    queue_hit(13'h0000, 12'hAAA, 1'b1);
    queue_hit(13'h1FFF, 12'h555, 1'b1);
    for (int i = 0; i < 20; i++) begin
      queue_load(thf_pkg::CHAN_W'($urandom), thf_pkg::TOWER_W'($urandom));
    end
    wait_quiet();

    // Random phases across settings and idling profiles.
    run_phase(0, 0, 1, 0, 0, 40);
    run_phase(4095, 127, 0, 75, 0, 40);
    run_phase($urandom_range(10, 4095), thf_pkg::MAX_LIST, 1, 0, 75, 40);
    run_phase($urandom_range(10, 600), $urandom_range(10, 64), 1, 36, 36, 40);

    // Long receiver hold while the sender keeps offering an event that stops.
    set_config(0, 10, 1);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      queue_hit(mapped_chans[$urandom_range(mapped_chans.size() - 1)],
                thf_pkg::ADC_W'($urandom), i == 39);
    end
    queue_event(10);
    wait_quiet();

    $display("Covered %0d hits in %0d events (%0d stopped early) and %0d map loads.",
             n_hits, n_events, n_stopped, n_loads);
    $display("Checked %0d raw, %0d accepted and %0d header words.",
             n_by_kind[thf_pkg::KIND_RAW], n_by_kind[thf_pkg::KIND_ACC],
             n_by_kind[thf_pkg::KIND_HDR]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* tower_hit_threshold_filter_top.f */
+incdir+sv
sv/thf_pkg.sv
sv/thf_ram.sv
sv/thf_front.sv
sv/thf_queue.sv
sv/thf_back.sv
sv/tower_hit_threshold_filter_top.sv
bench/tower_hit_threshold_filter_top_test.sv
